// File: rtl/okvt_pkg.sv
// shared types and codes for the ordered key/value table
// operation and status codes, word field widths, core control struct
// no dependencies
package okvt_pkg;

   localparam int KEY_W = 32;
   localparam int VAL_W = 32;
   localparam int OP_W  = 3;
   localparam int ST_W  = 3;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT  = 3'd0,
      OP_LOOKUP  = 3'd1,
      OP_REMOVE  = 3'd2,
      OP_REWIND  = 3'd3,
      OP_ADVANCE = 3'd4
   } okvt_op_type;

   typedef enum logic [ST_W-1:0] {
      ST_INSERTED  = 3'd0,
      ST_UPDATED   = 3'd1,
      ST_FOUND     = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_REMOVED   = 3'd4,
      ST_FULL      = 3'd5,
      ST_DONE      = 3'd6
   } okvt_stat_type;

   // core to top: handshake and result flags
   typedef struct packed {
      logic          ready;
      logic          done;
      okvt_stat_type status;
      logic          cursor_valid;
   } okvt_ctl_type;

endpackage

// File: rtl/okvt_core.sv
// sequencer and entry store of the ordered key/value table
// scans, shifts and cursor updates over a single-port-read entry memory
// depends on okvt_pkg
module okvt_core #(
   parameter int CAPACITY = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  okvt_pkg::okvt_op_type               op,
   input  logic [okvt_pkg::KEY_W-1:0]          key,
   input  logic [okvt_pkg::VAL_W-1:0]          value,
   input  logic                                take,
   output okvt_pkg::okvt_ctl_type              ctl,
   output logic [okvt_pkg::VAL_W-1:0]          value_out,
   output logic [$clog2(CAPACITY+1)-1:0]       entry_count,
   output logic [okvt_pkg::KEY_W-1:0]          cursor_key,
   output logic [okvt_pkg::VAL_W-1:0]          cursor_value
);

   localparam int AW    = $clog2(CAPACITY);
   localparam int CW    = $clog2(CAPACITY+1);
   localparam int WORDW = okvt_pkg::KEY_W + okvt_pkg::VAL_W;
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_INS_RD,
      S_INS_WR,
      S_RM_RD,
      S_RM_WR,
      S_FETCH,
      S_OUT
   } state_type;

   state_type               state_ff, state_in;
   okvt_pkg::okvt_op_type   op_ff, op_in;
   logic [okvt_pkg::KEY_W-1:0] key_ff, key_in;
   logic [okvt_pkg::VAL_W-1:0] val_ff, val_in;
   logic [okvt_pkg::VAL_W-1:0] vout_ff, vout_in;
   okvt_pkg::okvt_stat_type stat_ff, stat_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           cursor_ff, cursor_in;
   logic [CW-1:0]           idx_ff, idx_in;

   logic [WORDW-1:0]        mem [CAPACITY];
   logic [WORDW-1:0]        rd_data_ff;
   logic [AW-1:0]           rd_addr;
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic [WORDW-1:0]        wr_data;

   logic [okvt_pkg::KEY_W-1:0] rd_key;
   logic [okvt_pkg::VAL_W-1:0] rd_val;
   logic [CW-1:0]           idx_nxt, idx_prv, cursor_inc, cur_dec, count_dec;
   logic                    cursor_on;

   // entry word: key in the low half, value in the high half
   assign rd_key     = rd_data_ff[okvt_pkg::KEY_W-1:0];
   assign rd_val     = rd_data_ff[WORDW-1:okvt_pkg::KEY_W];
   assign idx_nxt    = idx_ff + 1'b1;
   assign idx_prv    = idx_ff - 1'b1;
   assign cursor_inc = cursor_ff + 1'b1;
   assign count_dec  = count_ff - 1'b1;
   assign cursor_on  = (cursor_ff < count_ff);
   assign cur_dec    = (cursor_ff > idx_ff) ? cursor_ff - 1'b1 : cursor_ff;

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      key_in    = key_ff;
      val_in    = val_ff;
      vout_in   = vout_ff;
      stat_in   = stat_ff;
      count_in  = count_ff;
      cursor_in = cursor_ff;
      idx_in    = idx_ff;
      rd_addr   = cursor_ff[AW-1:0];
      wr_en     = 1'b0;
      wr_addr   = idx_ff[AW-1:0];
      wr_data   = {val_ff, key_ff};
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in   = op;
               key_in  = key;
               val_in  = value;
               vout_in = '0;
               stat_in = okvt_pkg::ST_DONE;
               idx_in  = '0;
               case (op) inside
                  okvt_pkg::OP_INSERT, okvt_pkg::OP_LOOKUP, okvt_pkg::OP_REMOVE: begin
                     state_in = S_SCAN_RD;
                  end
                  okvt_pkg::OP_REWIND: begin
                     cursor_in = (count_ff != '0) ? '0 : CAP_C;
                     state_in  = S_FETCH;
                  end
                  okvt_pkg::OP_ADVANCE: begin
                     if (cursor_on) begin
                        cursor_in = (cursor_inc >= count_ff) ? CAP_C : cursor_inc;
                     end
                     state_in = S_FETCH;
                  end
                  default: begin
                     state_in = S_FETCH;
                  end
               endcase
            end
         end
         S_SCAN_RD: begin
            if (idx_ff == count_ff) begin
               // key absent
               if (op_ff == okvt_pkg::OP_INSERT) begin
                  if (count_ff == CAP_C) begin
                     stat_in  = okvt_pkg::ST_FULL;
                     state_in = S_FETCH;
                  end else begin
                     idx_in   = count_ff;
                     state_in = S_INS_RD;
                  end
               end else begin
                  stat_in  = okvt_pkg::ST_NOT_FOUND;
                  state_in = S_FETCH;
               end
            end else begin
               rd_addr  = idx_ff[AW-1:0];
               state_in = S_SCAN_CMP;
            end
         end
         S_SCAN_CMP: begin
            if (rd_key == key_ff) begin
               case (op_ff)
                  okvt_pkg::OP_INSERT: begin
                     wr_en    = 1'b1;
                     stat_in  = okvt_pkg::ST_UPDATED;
                     state_in = S_FETCH;
                  end
                  okvt_pkg::OP_LOOKUP: begin
                     vout_in  = rd_val;
                     stat_in  = okvt_pkg::ST_FOUND;
                     state_in = S_FETCH;
                  end
                  default: begin
                     // remove: the cursor follows its entry, or moves to the next one
                     if (cursor_on) begin
                        cursor_in = (cur_dec >= count_dec) ? CAP_C : cur_dec;
                     end
                     stat_in  = okvt_pkg::ST_REMOVED;
                     state_in = S_RM_RD;
                  end
               endcase
            end else begin
               idx_in   = idx_nxt;
               state_in = S_SCAN_RD;
            end
         end
         S_INS_RD: begin
            if (idx_ff == '0) begin
               wr_en = 1'b1;
               if (cursor_on) begin
                  cursor_in = cursor_inc;
               end
               count_in = count_ff + 1'b1;
               stat_in  = okvt_pkg::ST_INSERTED;
               state_in = S_FETCH;
            end else begin
               rd_addr  = idx_prv[AW-1:0];
               state_in = S_INS_WR;
            end
         end
         S_INS_WR: begin
            wr_en    = 1'b1;
            wr_data  = rd_data_ff;
            idx_in   = idx_prv;
            state_in = S_INS_RD;
         end
         S_RM_RD: begin
            if (idx_nxt >= count_ff) begin
               count_in = count_dec;
               state_in = S_FETCH;
            end else begin
               rd_addr  = idx_nxt[AW-1:0];
               state_in = S_RM_WR;
            end
         end
         S_RM_WR: begin
            wr_en    = 1'b1;
            wr_data  = rd_data_ff;
            idx_in   = idx_nxt;
            state_in = S_RM_RD;
         end
         S_FETCH: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         cursor_ff <= CAP_C;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         cursor_ff <= cursor_in;
      end
      op_ff   <= op_in;
      key_ff  <= key_in;
      val_ff  <= val_in;
      vout_ff <= vout_in;
      stat_ff <= stat_in;
      idx_ff  <= idx_in;
   end

   // entry store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign ctl.ready        = (state_ff == S_IDLE);
   assign ctl.done         = (state_ff == S_OUT);
   assign ctl.status       = stat_ff;
   assign ctl.cursor_valid = cursor_on;
   assign value_out        = vout_ff;
   assign entry_count      = count_ff;
   assign cursor_key       = cursor_on ? rd_key : '0;
   assign cursor_value     = cursor_on ? rd_val : '0;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_C)
      else $error("entry count above capacity");

   a_cursor_range : assert property (@(posedge clock) disable iff (reset)
      (cursor_ff < count_ff) || (cursor_ff == CAP_C))
      else $error("cursor neither on an entry nor at end");

   a_start_leaves_idle : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && start) |=> (state_ff != S_IDLE))
      else $error("accepted word did not start the sequencer");

   a_result_holds : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && !take) |=>
         (state_ff == S_OUT && $stable(count_ff) && $stable(cursor_ff) &&
          $stable(cursor_key) && $stable(cursor_value)))
      else $error("pending result changed before it was taken");

endmodule

// File: rtl/ordered_key_value_table_top.sv
// lookup, update and remove first scan the entries from slot 0 for the key; cursor ops only fetch
// remove then shifts the later entries forward one slot; an insert of a new key scans, then
// shifts the entries back one slot at a time and writes the new entry into slot 0
// one word in flight; the core returns to idle after each result is taken
// results wait in an output register, so the next word is taken while one is pending
// reset: synchronous, active high; table empty, cursor at end, no result pending
module ordered_key_value_table_top #(
   parameter int CAPACITY = 16
) (
   input  logic                                       clock,
   input  logic                                       reset,
   // request channel
   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   // [31:0] key, [63:32] value
   input  logic [63:0]                                req_tdata,
   // [2:0] op
   input  logic [okvt_pkg::OP_W-1:0]                  req_tuser,
   // response channel
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   // [31:0] value_out, then entry_count, cursor_key, cursor_value, zero pad to bytes
   output logic [((96+$clog2(CAPACITY+1)+7)/8)*8-1:0] rsp_tdata,
   // [2:0] status, [3] cursor_valid
   output logic [3:0]                                 rsp_tuser
);

   localparam int CW    = $clog2(CAPACITY+1);
   localparam int RSP_W = ((96+CW+7)/8)*8;

   okvt_pkg::okvt_ctl_type     ctl;
   logic                       start;
   logic                       take;
   logic [okvt_pkg::VAL_W-1:0] value_out;
   logic [CW-1:0]              entry_count;
   logic [okvt_pkg::KEY_W-1:0] cursor_key;
   logic [okvt_pkg::VAL_W-1:0] cursor_value;

   logic                       rsp_valid_ff;
   logic [RSP_W-1:0]           rsp_data_ff;
   logic [3:0]                 rsp_user_ff;

   // word accepted only while the sequencer is idle
   assign req_tready = ctl.ready;
   assign start      = req_tvalid && ctl.ready;

   // finished result moves to the output register once that is free
   assign take = ctl.done && (!rsp_valid_ff || rsp_tready);

   okvt_core #(
      .CAPACITY (CAPACITY)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .op           (okvt_pkg::okvt_op_type'(req_tuser)),
      .key          (req_tdata[31:0]),
      .value        (req_tdata[63:32]),
      .take         (take),
      .ctl          (ctl),
      .value_out    (value_out),
      .entry_count  (entry_count),
      .cursor_key   (cursor_key),
      .cursor_value (cursor_value)
   );

   // output register: valid is control, payload loads on take
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (take) begin
         rsp_data_ff <= RSP_W'({cursor_value, cursor_key, entry_count, value_out});
         rsp_user_ff <= {ctl.cursor_valid, ctl.status};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
